[src/qslerp_pkg.sv]
// Package for the quaternion slerp core: payload types, pipeline sizes and the arctangent table.
`timescale 1ns / 1ps
package qslerp_pkg;

  localparam int FRAC_BITS     = 15;
  localparam int ONE           = 1 << FRAC_BITS;
  localparam int CORDIC_STAGES = 16;
  localparam int SQ_N          = 31;
  localparam int DV_N          = 32;

  localparam logic signed [33:0] INV_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_z;
    logic signed [15:0] left_w;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] right_w;
    logic        [15:0] blend;
  } qslerp_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
  } qslerp_out_t;

  // Values that travel down the whole pipeline beside the arithmetic.
  typedef struct packed {
    logic [3:0][15:0] l;
    logic [3:0][16:0] r;
    logic [15:0]      t;
    logic [15:0]      c;
    logic             slerp;
    logic [30:0]      s30;
  } qslerp_carry_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    unique case (i)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      24: v = 34'sd63;
      25: v = 34'sd31;
      26: v = 34'sd15;
      27: v = 34'sd7;
      28: v = 34'sd3;
      29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

[src/quaternion_slerp_core.sv]
// Top level of the quaternion slerp core: a fully pipelined slerp datapath.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o    in_data_i  (qslerp_in_t)
//   out       output     out_valid_o / out_ready_i  out_data_o (qslerp_out_t)
//   cfg       input      cfg_we_i                   cfg_wdata_i (lerp threshold)
//
// One item enters per cycle while the output register is empty or taken; each item passes 104
// register stages before its result is offered. The depth is set by the 31-step square root,
// the two 16-stage CORDICs and the 32-step dividers.
// Reset clears only the valid bits and sets the threshold to 3.
// When the output register holds an item that is not taken, the whole pipeline holds.
`timescale 1ns / 1ps
module quaternion_slerp_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  qslerp_pkg::qslerp_in_t   in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output qslerp_pkg::qslerp_out_t  out_data_o,
  input  logic                     cfg_we_i,
  input  logic [14:0]              cfg_wdata_i
);
  import qslerp_pkg::*;

  localparam int CS    = CORDIC_STAGES;
  localparam int P_IN  = 0;
  localparam int P_DOT = 1;
  localparam int P_SQ  = 2;
  localparam int P_VC  = P_SQ + SQ_N + 1;
  localparam int P_ROT = P_VC + CS + 1;
  localparam int P_DV  = P_ROT + CS + 1;
  localparam int P_CF  = P_DV + DV_N + 1;
  localparam int P_MUL = P_CF + 1;
  localparam int P_OUT = P_MUL + 1;
  localparam int NPOS  = P_OUT + 1;

  logic            adv;
  logic [14:0]     thr_q;
  logic [NPOS-1:0] valid_q;
  qslerp_carry_t   car_q [NPOS];
  qslerp_carry_t   car_d [NPOS];

  assign adv         = !valid_q[NPOS-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = valid_q[NPOS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 15'd3;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (adv) begin
        valid_q <= {valid_q[NPOS-2:0], in_valid_i};
      end
    end
  end

  // Input stage and dot product terms.
  logic signed [31:0] prod_q [4];
  logic signed [15:0] in_l [4];
  logic signed [15:0] in_r [4];

  assign in_l[0] = in_data_i.left_x;
  assign in_l[1] = in_data_i.left_y;
  assign in_l[2] = in_data_i.left_z;
  assign in_l[3] = in_data_i.left_w;
  assign in_r[0] = in_data_i.right_x;
  assign in_r[1] = in_data_i.right_y;
  assign in_r[2] = in_data_i.right_z;
  assign in_r[3] = in_data_i.right_w;

  // Dot stage signals.
  logic signed [33:0] dot;
  logic        [33:0] abs_dot;
  logic        [18:0] c_raw;
  logic        [15:0] c_cl;
  logic               dot_neg;

  always_comb begin
    dot = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
    dot_neg = dot < 0;
    abs_dot = dot_neg ? 34'(-dot) : 34'(dot);
    c_raw   = abs_dot[33:FRAC_BITS];
    c_cl    = (c_raw > 19'(ONE)) ? 16'(ONE) : c_raw[15:0];
  end

  // Square root, vectoring and rotation CORDIC, divider storage.
  logic [63:0]        sq_rem_q  [SQ_N+1];
  logic [30:0]        sq_root_q [SQ_N+1];
  logic signed [33:0] vx_q [CS+1];
  logic signed [33:0] vy_q [CS+1];
  logic signed [33:0] vz_q [CS+1];
  logic signed [33:0] rx_q [2][CS+1];
  logic signed [33:0] ry_q [2][CS+1];
  logic signed [33:0] rz_q [2][CS+1];
  logic [63:0]        dv_rem_q [2][DV_N+1];
  logic [31:0]        dv_quo_q [2][DV_N+1];
  logic               dv_ovf_q [2][DV_N+1];
  logic [31:0]        cf_q [2];
  logic signed [49:0] ml_q [4];
  logic signed [49:0] mr_q [4];
  qslerp_out_t        out_q;

  always_comb begin
    car_d[P_IN].t     = (in_data_i.blend > 16'(ONE)) ? 16'(ONE) : in_data_i.blend;
    car_d[P_IN].c     = '0;
    car_d[P_IN].slerp = 1'b0;
    car_d[P_IN].s30   = '0;
    for (int k = 0; k < 4; k++) begin
      car_d[P_IN].l[k] = in_l[k];
      car_d[P_IN].r[k] = 17'(in_r[k]);
    end
    for (int p = 1; p < NPOS; p++) begin
      car_d[p] = car_q[p-1];
    end
    for (int k = 0; k < 4; k++) begin
      car_d[P_DOT].r[k] = dot_neg ? 17'(-$signed(car_q[P_IN].r[k])) : car_q[P_IN].r[k];
    end
    car_d[P_DOT].c     = c_cl;
    car_d[P_DOT].slerp = (17'(ONE) - 17'(c_cl)) > 17'(thr_q);
    car_d[P_VC].s30    = sq_root_q[SQ_N];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < NPOS; p++) begin
        car_q[p] <= car_d[p];
      end
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= in_l[k] * in_r[k];
      end
    end
  end

  // Radicand (2^30 - c^2) * 2^30 for sin(omega) in Q30.
  logic [31:0] c_sq;
  logic [30:0] rad_m;
  assign c_sq  = 32'(car_q[P_DOT].c) * 32'(car_q[P_DOT].c);
  assign rad_m = 31'(32'h4000_0000 - c_sq);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q[0]  <= 64'(rad_m) << 30;
      sq_root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam int BI = SQ_N - 1 - j;
    logic [63:0] trial;
    assign trial = (64'(sq_root_q[j]) << (BI + 1)) + (64'd1 << (2 * BI));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (sq_rem_q[j] >= trial) begin
          sq_rem_q[j+1]  <= sq_rem_q[j] - trial;
          sq_root_q[j+1] <= sq_root_q[j] | (31'd1 << BI);
        end else begin
          sq_rem_q[j+1]  <= sq_rem_q[j];
          sq_root_q[j+1] <= sq_root_q[j];
        end
      end
    end
  end

  // Vectoring CORDIC: omega = atan2(sin, cos).
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx_q[0] <= 34'(car_q[P_VC-1].c) << (30 - FRAC_BITS);
      vy_q[0] <= $signed(34'(sq_root_q[SQ_N]));
      vz_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_vec
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    assign dx = vy_q[i] >>> i;
    assign dy = vx_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (vy_q[i] > 0) begin
          vx_q[i+1] <= vx_q[i] + dx;
          vy_q[i+1] <= vy_q[i] - dy;
          vz_q[i+1] <= vz_q[i] + atan_q30(i);
        end else begin
          vx_q[i+1] <= vx_q[i] - dx;
          vy_q[i+1] <= vy_q[i] + dy;
          vz_q[i+1] <= vz_q[i] - atan_q30(i);
        end
      end
    end
  end

  // Angles (1-t)*omega and t*omega, then two rotation CORDICs for their sines.
  logic [30:0] omega;
  logic [47:0] ang [2];
  assign omega  = (vz_q[CS] < 0) ? 31'd0 : vz_q[CS][30:0];
  assign ang[0] = 48'(17'(ONE) - 17'(car_q[P_ROT-1].t)) * 48'(omega);
  assign ang[1] = 48'(car_q[P_ROT-1].t) * 48'(omega);

  for (genvar n = 0; n < 2; n++) begin : g_lane
    logic [30:0] sine;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rx_q[n][0] <= INV_GAIN;
        ry_q[n][0] <= '0;
        rz_q[n][0] <= $signed(34'(ang[n] >> FRAC_BITS));
      end
    end

    for (genvar i = 0; i < CS; i++) begin : g_rot
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      assign dx = ry_q[n][i] >>> i;
      assign dy = rx_q[n][i] >>> i;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (rz_q[n][i] >= 0) begin
            rx_q[n][i+1] <= rx_q[n][i] - dx;
            ry_q[n][i+1] <= ry_q[n][i] + dy;
            rz_q[n][i+1] <= rz_q[n][i] - atan_q30(i);
          end else begin
            rx_q[n][i+1] <= rx_q[n][i] + dx;
            ry_q[n][i+1] <= ry_q[n][i] - dy;
            rz_q[n][i+1] <= rz_q[n][i] + atan_q30(i);
          end
        end
      end
    end

    always_comb begin
      if (ry_q[n][CS] < 0) begin
        sine = '0;
      end else if (ry_q[n][CS] > 34'sd1073741824) begin
        sine = 31'h4000_0000;
      end else begin
        sine = ry_q[n][CS][30:0];
      end
    end

    // Quotients of 2^32 and above can only clamp, so they are flagged up front.
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[n][0] <= 64'(sine) << 30;
        dv_quo_q[n][0] <= '0;
        dv_ovf_q[n][0] <= 33'(sine) >= (33'(car_q[P_DV-1].s30) << 2);
      end
    end

    for (genvar j = 0; j < DV_N; j++) begin : g_div
      localparam int BI = DV_N - 1 - j;
      logic [63:0] sh;
      assign sh = 64'(car_q[P_DV+j].s30) << BI;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_ovf_q[n][j+1] <= dv_ovf_q[n][j];
          if (dv_rem_q[n][j] >= sh) begin
            dv_rem_q[n][j+1] <= dv_rem_q[n][j] - sh;
            dv_quo_q[n][j+1] <= dv_quo_q[n][j] | (32'd1 << BI);
          end else begin
            dv_rem_q[n][j+1] <= dv_rem_q[n][j];
            dv_quo_q[n][j+1] <= dv_quo_q[n][j];
          end
        end
      end
    end
  end

  // Coefficient choice: slerp quotients, clamped, or the linear weights.
  logic        use_slerp;
  logic [31:0] cf_d [2];
  always_comb begin
    use_slerp = car_q[P_CF-1].slerp && (car_q[P_CF-1].s30 != '0);
    for (int n = 0; n < 2; n++) begin
      if (dv_ovf_q[n][DV_N] || (dv_quo_q[n][DV_N] > 32'h8000_0000)) begin
        cf_d[n] = 32'h8000_0000;
      end else begin
        cf_d[n] = dv_quo_q[n][DV_N];
      end
    end
    if (!use_slerp) begin
      cf_d[0] = 32'(17'(ONE) - 17'(car_q[P_CF-1].t)) << (30 - FRAC_BITS);
      cf_d[1] = 32'(car_q[P_CF-1].t) << (30 - FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cf_q <= cf_d;
      for (int k = 0; k < 4; k++) begin
        ml_q[k] <= $signed({1'b0, cf_q[0]}) * $signed(car_q[P_MUL-1].l[k]);
        mr_q[k] <= $signed({1'b0, cf_q[1]}) * $signed(car_q[P_MUL-1].r[k]);
      end
    end
  end

  // Round to nearest, floor shift and saturate.
  logic signed [15:0] res [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [51:0] s;
      logic signed [21:0] v;
      s = 52'(ml_q[k]) + 52'(mr_q[k]) + 52'sd536870912;
      v = 22'(s >>> 30);
      if (v > 22'sd32767) begin
        res[k] = 16'sh7fff;
      end else if (v < -22'sd32768) begin
        res[k] = 16'sh8000;
      end else begin
        res[k] = v[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_x <= res[0];
      out_q.out_y <= res[1];
      out_q.out_z <= res[2];
      out_q.out_w <= res[3];
    end
  end

  assign out_data_o = out_q;

endmodule

[tb/quaternion_slerp_core_tb.sv]
// Self-checking testbench for the quaternion slerp core: directed and random items with a bit-exact predictor.
`timescale 1ns / 1ps
module quaternion_slerp_core_tb;
  import qslerp_pkg::*;

  localparam int          LATENCY     = 104;
  localparam longint      CYCLE_LIMIT = 400000;
  localparam longint      Q30         = longint'(1) << 30;
  localparam logic [14:0] THR_RESET   = 15'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  qslerp_in_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  qslerp_out_t out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;

  logic [14:0] lerp_margin = THR_RESET;
  qslerp_out_t expected_q[$];
  int          mismatches = 0;
  longint      cycles = 0;
  bit          idle_on = 1'b1;
  int          out_hold = 0;

  longint atan_tab[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                           33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                           524287, 262143, 131071, 65535, 32767};

  quaternion_slerp_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint arc_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint sine_of(longint z);
    longint x, y, dx, dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (y < 0) y = 0;
    if (y > Q30) y = Q30;
    return y;
  endfunction

  function automatic qslerp_out_t slerp_of(qslerp_in_t it, logic [14:0] margin);
    longint l[4], r[4], dot, c, t, p, q, c30, s30, w, sa, sb, v;
    qslerp_out_t res;
    l[0] = it.left_x;  l[1] = it.left_y;  l[2] = it.left_z;  l[3] = it.left_w;
    r[0] = it.right_x; r[1] = it.right_y; r[2] = it.right_z; r[3] = it.right_w;
    dot = 0;
    for (int k = 0; k < 4; k++) dot += l[k] * r[k];
    t = longint'(it.blend);
    if (t > ONE) t = ONE;
    // Take the shorter arc; a zero dot leaves the second quaternion alone.
    if (dot < 0) begin
      dot = -dot;
      for (int k = 0; k < 4; k++) r[k] = -r[k];
    end
    c = dot >>> FRAC_BITS;
    if (c > ONE) c = ONE;
    p = (ONE - t) <<< (30 - FRAC_BITS);
    q = t <<< (30 - FRAC_BITS);
    if ((ONE - c) > longint'(margin)) begin
      c30 = c <<< (30 - FRAC_BITS);
      s30 = root_floor((longint'(1) << 60) - c30 * c30);
      if (s30 > 0) begin
        w = arc_angle(c30, s30);
        if (w < 0) w = 0;
        sa = sine_of(((ONE - t) * w) >>> FRAC_BITS);
        sb = sine_of((t * w) >>> FRAC_BITS);
        p = (sa <<< 30) / s30;
        q = (sb <<< 30) / s30;
        if (p > 2 * Q30) p = 2 * Q30;
        if (q > 2 * Q30) q = 2 * Q30;
      end
    end
    for (int k = 0; k < 4; k++) begin
      v = (p * l[k] + q * r[k] + (Q30 >>> 1)) >>> 30;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      case (k)
        0: res.out_x = v[15:0];
        1: res.out_y = v[15:0];
        2: res.out_z = v[15:0];
        default: res.out_w = v[15:0];
      endcase
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quaternion_slerp_core regression: fail");
      $finish;
    end
  end

  // Result checker and receiver stall control.
  always @(posedge clk_i) begin
    qslerp_out_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item %h", $time, out_data_o);
      end else begin
        exp_v = expected_q.pop_front();
        if (exp_v.out_x !== out_data_o.out_x)
          $display("%0t: out_x expected %0d actual %0d", $time, exp_v.out_x, out_data_o.out_x);
        if (exp_v.out_y !== out_data_o.out_y)
          $display("%0t: out_y expected %0d actual %0d", $time, exp_v.out_y, out_data_o.out_y);
        if (exp_v.out_z !== out_data_o.out_z)
          $display("%0t: out_z expected %0d actual %0d", $time, exp_v.out_z, out_data_o.out_z);
        if (exp_v.out_w !== out_data_o.out_w)
          $display("%0t: out_w expected %0d actual %0d", $time, exp_v.out_w, out_data_o.out_w);
        if (exp_v !== out_data_o) mismatches++;
      end
      out_hold = idle_on ? $urandom_range(0, 7) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_ready_i = 1'b0;
      out_hold--;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  task automatic send_item(qslerp_in_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(slerp_of(it, lerp_margin));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic write_margin(logic [14:0] value);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    lerp_margin = value;
  endtask

  function automatic qslerp_in_t build(int lx, int ly, int lz, int lw,
                                       int rx, int ry, int rz, int rw, int t);
    qslerp_in_t it;
    it.left_x  = lx[15:0]; it.left_y  = ly[15:0];
    it.left_z  = lz[15:0]; it.left_w  = lw[15:0];
    it.right_x = rx[15:0]; it.right_y = ry[15:0];
    it.right_z = rz[15:0]; it.right_w = rw[15:0];
    it.blend   = t[15:0];
    return it;
  endfunction

  // Random unit quaternion scaled to Q1.15, optionally tilted away from a base one by up to the given spread.
  function automatic void unit_quat(ref int q[4], input bit near, input int base[4], input int spread);
    real v[4], n;
    n = 0.0;
    for (int k = 0; k < 4; k++) begin
      if (near) v[k] = real'(base[k] + int'($urandom_range(0, 2 * spread)) - spread);
      else v[k] = real'($urandom_range(0, 20000)) - 10000.0;
      n += v[k] * v[k];
    end
    if (n == 0.0) begin v[3] = 1.0; n = 1.0; end
    n = $sqrt(n);
    for (int k = 0; k < 4; k++) q[k] = int'(v[k] / n * 32767.0);
  endfunction

  function automatic int pick_blend();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return ONE;
      2: return $urandom_range(ONE + 1, 65535);
      default: return $urandom_range(0, ONE);
    endcase
  endfunction

  task automatic test_reset_margin();
    send_item(build(0, 0, 0, 32767, 0, 0, 0, 32767, 16384));
    send_item(build(0, 0, 0, 32767, 0, 0, 32, 32767, 16384));
    send_item(build(0, 0, 0, 32767, 0, 0, 400, 32767, 8000));
  endtask

  task automatic test_directed();
    send_item(build(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(build(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, ONE));
    send_item(build(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 65535));
    send_item(build(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 12345));
    send_item(build(32767, 0, 0, 0, 0, 32767, 0, 0, 16384));
    send_item(build(32767, 0, 0, 0, 0, 32767, 0, 0, 0));
    send_item(build(32767, 0, 0, 0, 0, 32767, 0, 0, ONE));
    send_item(build(0, 0, 0, 32767, 0, 0, 0, -32768, 20000));
    send_item(build(23170, 0, 0, 23170, 0, 23170, 0, 23170, 16384));
    send_item(build(23170, 0, 0, 23170, -23170, 0, 0, -23170, 30000));
    send_item(build(16384, 16384, 16384, 16384, -16384, 16384, 16384, 16384, 4096));
    send_item(build(-32768, 0, 0, 0, 32767, 0, 0, 0, 16384));
    send_item(build(16000, -16000, 16000, 16000, 15000, -17000, 15500, 16500, 40000));
    send_item(build(32767, -32768, 21, -7, -1, 1, 32767, -32768, 32767));
  endtask

  task automatic test_random(int count);
    int a[4], b[4], pick, spread;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) idle_on = (n % 300 != 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        unit_quat(a, 1'b0, a, 0);
        case ($urandom_range(0, 2))
          0: spread = 40;
          1: spread = 2000;
          default: spread = 12000;
        endcase
        unit_quat(b, 1'b1, a, spread);
        if ($urandom_range(0, 1)) for (int k = 0; k < 4; k++) b[k] = -b[k];
        if (pick == 6) unit_quat(b, 1'b0, a, 0);
        send_item(build(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3], pick_blend()));
      end else begin
        send_item(build($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom));
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic test_margin_settings();
    logic [14:0] settings[5];
    settings = '{15'd0, 15'd32767, 15'd1, 15'd200, 15'd3};
    foreach (settings[i]) begin
      write_margin(settings[i]);
      test_directed();
      test_random(60);
    end
    write_margin(15'($urandom_range(0, 32767)));
    test_random(60);
    write_margin(THR_RESET);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_margin();
    test_directed();
    test_margin_settings();
    test_random(850);
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("quaternion_slerp_core regression: pass");
    end else begin
      $display("quaternion_slerp_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/qslerp_pkg.sv
src/quaternion_slerp_core.sv
tb/quaternion_slerp_core_tb.sv
